// ===== rtl/core/contrast_stretch_min_max_defines.svh =====
// ------------------------------------------------------------------------
// Contrast stretch assertion macros
// Shared helpers for the concurrent checks of the contrast stretch block.
// ------------------------------------------------------------------------
`ifndef CONTRAST_STRETCH_MIN_MAX_DEFINES_SVH
`define CONTRAST_STRETCH_MIN_MAX_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CSMM_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define CSMM_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/core/csmm_pkg.sv =====
// ------------------------------------------------------------------------
// Contrast stretch package
// Types, constants and status structs shared by the contrast stretch block.
// ------------------------------------------------------------------------
package csmm_pkg;

	localparam int PIX_W      = 8;
	localparam int FULL_SCALE = 255;

	// Map queue between the classifier and the divider.
	localparam int QDEPTH = 2;
	localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	// One quotient bit per divider step.
	localparam int DIV_STEPS = PIX_W;
	localparam int DCNT_W    = $clog2(DIV_STEPS);

	typedef logic [PIX_W-1:0] pix_t;

	// Input opcodes.
	localparam logic OP_MEASURE = 1'b0;
	localparam logic OP_MAP     = 1'b1;

	// How the back end produces a map result.
	typedef enum logic {
		KIND_DIRECT,
		KIND_DIVIDE
	} kind_t;

	// A classified map request: a ready result or a division to run.
	typedef struct packed {
		kind_t kind;
		pix_t  value;
		pix_t  span;
	} entry_t;

	typedef struct packed {
		logic [QCNT_W-1:0] count;
		logic              full;
		logic              empty;
	} q_status_t;

	typedef struct packed {
		pix_t run_min;
		pix_t run_max;
	} front_status_t;

	typedef struct packed {
		logic busy;
		logic pop;
	} back_status_t;

endpackage

// ===== rtl/core/csmm_if.sv =====
// ------------------------------------------------------------------------
// Contrast stretch channel interfaces
// Valid/ready channels for pixel requests and stretched pixel results.
// ------------------------------------------------------------------------
interface csmm_in_if;
	import csmm_pkg::*;

	logic valid;
	logic ready;
	logic opcode;
	pix_t pixel;
	logic first;

	modport source (output valid, output opcode, output pixel, output first, input ready);
	modport sink   (input valid, input opcode, input pixel, input first, output ready);
endinterface

interface csmm_out_if;
	import csmm_pkg::*;

	logic valid;
	logic ready;
	pix_t pixel_out;

	modport source (output valid, output pixel_out, input ready);
	modport sink   (input valid, input pixel_out, output ready);
endinterface

// ===== rtl/core/contrast_stretch_min_max.sv =====
// ------------------------------------------------------------------------
// Contrast stretch, min-max
// Two-pass linear stretch of 8-bit grayscale pixels: measure requests
// track the extremes, map requests return the stretched pixel.
// ------------------------------------------------------------------------
//  channel   dir  payload                  notes
//  pix_in    in   opcode, pixel, first     measure gives no result
//  pix_out   out  pixel_out                one per map request
//
// A measure request is taken and updates the extremes in the front end.
// A map request that saturates or passes through is offered on pix_out
// after the map queue and the output register; a stretched one also runs
// through the one-bit-per-cycle restoring divider, and the back end pops
// no new request from the queue while a divide is in flight.
// Reset clears the extremes, the queue and the output valid; no sweep.
// pix_in stalls only while the map queue is full; pix_out stalls hold it.
`include "contrast_stretch_min_max_defines.svh"

module contrast_stretch_min_max (
	input  logic        clk,
	input  logic        arst_n,
	csmm_in_if.sink     pix_in,
	csmm_out_if.source  pix_out
);
	import csmm_pkg::*;

	logic          push;
	entry_t        push_entry;
	entry_t        head;
	q_status_t     q_stat;
	front_status_t f_stat;
	back_status_t  b_stat;
	logic          measure_acc;

	csmm_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.pix_in     (pix_in),
		.q_full     (q_stat.full),
		.push       (push),
		.push_entry (push_entry),
		.stat       (f_stat)
	);

	csmm_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.pop        (b_stat.pop),
		.head       (head),
		.stat       (q_stat)
	);

	csmm_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_empty (q_stat.empty),
		.head    (head),
		.stat    (b_stat),
		.pix_out (pix_out)
	);

	// A measure request accepted while the back end takes nothing from the queue.
	assign measure_acc = pix_in.valid && pix_in.ready && (pix_in.opcode == OP_MEASURE) &&
		!b_stat.pop;

	// The extremes stay ordered.
	`CSMM_ASSERT_IMP(a_min_le_max, clk, arst_n, 1'b1, f_stat.run_min <= f_stat.run_max, "min above max")

	// The queue never holds more than its depth.
	`CSMM_ASSERT_IMP(a_q_bound, clk, arst_n, 1'b1, q_stat.count <= QCNT_W'(QDEPTH), "queue overfilled")

	// The back end takes nothing while a divide is in flight.
	`CSMM_ASSERT_IMP(a_no_pop_busy, clk, arst_n, b_stat.busy, !b_stat.pop, "pop while busy")

	// A measure request never enters the queue.
	`CSMM_ASSERT_NXT(a_measure_no_q, clk, arst_n, measure_acc, q_stat.count == $past(q_stat.count), "measure queued")

endmodule

// ===== rtl/core/csmm_front.sv =====
// ------------------------------------------------------------------------
// Contrast stretch front end
// Takes pixel requests, tracks the running minimum and maximum and turns
// each map request into a queue entry.
// ------------------------------------------------------------------------
module csmm_front (
	input  logic                    clk,
	input  logic                    arst_n,
	csmm_in_if.sink                 pix_in,
	input  logic                    q_full,
	output logic                    push,
	output csmm_pkg::entry_t        push_entry,
	output csmm_pkg::front_status_t stat
);
	import csmm_pkg::*;

	pix_t run_min_q;
	pix_t run_max_q;
	logic accept;

	// Requests wait only on queue room.
	assign pix_in.ready = !q_full;
	assign accept       = pix_in.valid && pix_in.ready;
	assign push         = accept && (pix_in.opcode == OP_MAP);

	// Running extremes; a first mark loads both from the pixel.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_min_q <= '0;
			run_max_q <= '0;
		end else if (accept && (pix_in.opcode == OP_MEASURE)) begin
			if (pix_in.first) begin
				run_min_q <= pix_in.pixel;
				run_max_q <= pix_in.pixel;
			end else begin
				if (pix_in.pixel < run_min_q) run_min_q <= pix_in.pixel;
				if (pix_in.pixel > run_max_q) run_max_q <= pix_in.pixel;
			end
		end
	end

	// Classify a map pixel against the extremes in force when it arrives.
	always_comb begin
		push_entry.kind  = KIND_DIRECT;
		push_entry.value = pix_in.pixel;
		push_entry.span  = run_max_q - run_min_q;
		priority if (run_max_q == run_min_q) begin
			push_entry.value = pix_in.pixel;
		end else if (pix_in.pixel <= run_min_q) begin
			push_entry.value = '0;
		end else if (pix_in.pixel >= run_max_q) begin
			push_entry.value = PIX_W'(FULL_SCALE);
		end else begin
			push_entry.kind  = KIND_DIVIDE;
			push_entry.value = pix_in.pixel - run_min_q;
		end
	end

	assign stat.run_min = run_min_q;
	assign stat.run_max = run_max_q;

endmodule

// ===== rtl/core/csmm_queue.sv =====
// ------------------------------------------------------------------------
// Contrast stretch map queue
// Short first-in first-out buffer of classified map requests.
// ------------------------------------------------------------------------
module csmm_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  csmm_pkg::entry_t    push_entry,
	input  logic                pop,
	output csmm_pkg::entry_t    head,
	output csmm_pkg::q_status_t stat
);
	import csmm_pkg::*;

	entry_t            slot_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	function automatic logic [QPTR_W-1:0] ptr_next(input logic [QPTR_W-1:0] p);
		return (p == QPTR_W'(QDEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	// Storage.
	always_ff @(posedge clk) begin
		if (push) slot_q[wr_ptr_q] <= push_entry;
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= ptr_next(wr_ptr_q);
			if (pop)  rd_ptr_q <= ptr_next(rd_ptr_q);
			if (push && !pop)      count_q <= count_q + 1'b1;
			else if (pop && !push) count_q <= count_q - 1'b1;
		end
	end

	assign head       = slot_q[rd_ptr_q];
	assign stat.count = count_q;
	assign stat.full  = (count_q == QCNT_W'(QDEPTH));
	assign stat.empty = (count_q == '0);

endmodule

// ===== rtl/core/csmm_back.sv =====
// ------------------------------------------------------------------------
// Contrast stretch back end
// Pops queue entries, runs a bit-serial restoring divide for stretched
// pixels and holds each result in the output register.
// ------------------------------------------------------------------------
module csmm_back (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   q_empty,
	input  csmm_pkg::entry_t       head,
	output csmm_pkg::back_status_t stat,
	csmm_out_if.source             pix_out
);
	import csmm_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_DIV  = 3'b010,
		ST_DONE = 3'b100
	} state_t;

	state_t            state_q;
	logic [DCNT_W-1:0] step_q;
	pix_t              span_q;
	pix_t              rem_q;
	pix_t              quo_q;
	logic              out_valid_q;
	pix_t              pixel_out_q;

	logic              out_free;
	logic              pop;
	logic [2*PIX_W-1:0] numer;
	logic [PIX_W:0]    trial;
	logic              fits;
	pix_t              rem_next;
	logic              load_out;
	pix_t              load_value;

	assign out_free = !out_valid_q || pix_out.ready;

	// A direct result needs the output register now; a divide needs only the unit.
	assign pop = (state_q == ST_IDLE) && !q_empty &&
		((head.kind == KIND_DIVIDE) || out_free);

	// Numerator diff * 255 as diff * 256 - diff.
	assign numer = {head.value, PIX_W'(0)} - {PIX_W'(0), head.value};

	// One restoring divide step.
	assign trial    = {rem_q, quo_q[PIX_W-1]};
	assign fits     = (trial >= {1'b0, span_q});
	assign rem_next = fits ? PIX_W'(trial - {1'b0, span_q}) : trial[PIX_W-1:0];

	// Output register loads.
	always_comb begin
		load_out   = 1'b0;
		load_value = head.value;
		if (pop && (head.kind == KIND_DIRECT)) begin
			load_out   = 1'b1;
			load_value = head.value;
		end else if ((state_q == ST_DONE) && out_free) begin
			load_out   = 1'b1;
			load_value = quo_q;
		end
	end

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q  <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (pop && (head.kind == KIND_DIVIDE)) begin
						state_q <= ST_DIV;
						step_q  <= '0;
					end
				end
				ST_DIV: begin
					step_q <= step_q + 1'b1;
					if (step_q == DCNT_W'(DIV_STEPS - 1)) state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (out_free) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Divider datapath: quotient bits shift in where numerator bits leave.
	always_ff @(posedge clk) begin
		if (pop && (head.kind == KIND_DIVIDE)) begin
			span_q <= head.span;
			rem_q  <= numer[2*PIX_W-1:PIX_W];
			quo_q  <= numer[PIX_W-1:0];
		end else if (state_q == ST_DIV) begin
			rem_q <= rem_next;
			quo_q <= {quo_q[PIX_W-2:0], fits};
		end
	end

	// Output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (pix_out.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) pixel_out_q <= load_value;
	end

	assign pix_out.valid     = out_valid_q;
	assign pix_out.pixel_out = pixel_out_q;
	assign stat.busy         = (state_q != ST_IDLE);
	assign stat.pop          = pop;

endmodule

// ===== test/tb_contrast_stretch_min_max.sv =====
`timescale 1ns / 1ps
// ------------------------------------------------------------------------
// Contrast stretch testbench
// Drives measure and map requests into the min-max contrast stretch block,
// predicts each stretched pixel from its own copy of the running extremes
// and checks the results in order, with random idling on both channels.
// ------------------------------------------------------------------------

module tb_contrast_stretch_min_max;
	import csmm_pkg::*;

	// Keeps the running extremes and the stretched pixels still owed.
	class stretch_scoreboard;
		pix_t lo;
		pix_t hi;
		pix_t owed_pixels[$];
		int   errors;

		function new();
			lo = '0;
			hi = '0;
			errors = 0;
		endfunction

		task report_mismatch(input string msg);
			$display("[%0t] MISMATCH: %s", $time, msg);
			errors++;
		endtask

		// Stretched value of a map pixel under the current extremes.
		function pix_t stretched(input pix_t px);
			int unsigned q;
			if (hi == lo)
				return px;
			if (px <= lo)
				return '0;
			if (px >= hi)
				return pix_t'(FULL_SCALE);
			q = (int'(px) - int'(lo)) * FULL_SCALE / (int'(hi) - int'(lo));
			if (q > FULL_SCALE)
				q = FULL_SCALE;
			return pix_t'(q);
		endfunction

		// An accepted request either moves the extremes or owes one result.
		function void note_request(input logic op, input pix_t px, input logic mark);
			if (op == OP_MEASURE) begin
				if (mark) begin
					lo = px;
					hi = px;
				end else begin
					if (px < lo)
						lo = px;
					if (px > hi)
						hi = px;
				end
			end else begin
				owed_pixels.push_back(stretched(px));
			end
		endfunction

		task check_result(input pix_t got);
			pix_t want;
			if (owed_pixels.size() == 0) begin
				report_mismatch($sformatf("unexpected result pixel_out=%0d", got));
			end else begin
				want = owed_pixels.pop_front();
				if (got !== want)
					report_mismatch($sformatf("pixel_out=%0d, expected %0d", got, want));
			end
		endtask
	endclass

	logic clk;
	logic arst_n;
	bit   calm;
	int   requests_sent;

	stretch_scoreboard board = new();

	csmm_in_if  pix_in_bus();
	csmm_out_if pix_out_bus();

	contrast_stretch_min_max uut (
		.clk     (clk),
		.arst_n  (arst_n),
		.pix_in  (pix_in_bus),
		.pix_out (pix_out_bus)
	);

	// Clock.
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Safety net against a hung handshake.
	initial begin
		#5_000_000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	// Both accepted requests and accepted results are seen at the clock edge.
	always @(posedge clk) begin
		if (pix_out_bus.valid && pix_out_bus.ready)
			board.check_result(pix_out_bus.pixel_out);
		if (pix_in_bus.valid && pix_in_bus.ready)
			board.note_request(pix_in_bus.opcode, pix_in_bus.pixel, pix_in_bus.first);
	end

	// Result side: random stalls, and two long hold-offs to fill the block.
	initial begin
		int results_taken;
		int hold_left;
		results_taken = 0;
		hold_left = 0;
		pix_out_bus.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (pix_out_bus.valid && pix_out_bus.ready) begin
				results_taken++;
				if (results_taken == 150 || results_taken == 700)
					hold_left = 300;
			end
			if (hold_left > 0) begin
				hold_left--;
				pix_out_bus.ready <= 1'b0;
			end else if (calm) begin
				pix_out_bus.ready <= 1'b1;
			end else begin
				pix_out_bus.ready <= ($urandom_range(99) >= 23);
			end
		end
	end

	// Offer one request, with a random gap first, and wait for its acceptance.
	task automatic send_request(input logic op, input pix_t px, input logic mark);
		while (!calm && $urandom_range(99) < 23) begin
			pix_in_bus.valid <= 1'b0;
			@(posedge clk);
		end
		pix_in_bus.valid  <= 1'b1;
		pix_in_bus.opcode <= op;
		pix_in_bus.pixel  <= px;
		pix_in_bus.first  <= mark;
		do @(posedge clk); while (!pix_in_bus.ready);
		requests_sent++;
	endtask

	// One image: a measure pass over a chosen range, then a map pass.
	task automatic send_image();
		int   lo_b;
		int   hi_b;
		int   n_measure;
		int   n_map;
		pix_t px;
		lo_b = $urandom_range(255);
		hi_b = ($urandom_range(7) == 0) ? lo_b : $urandom_range(255, lo_b);
		n_measure = $urandom_range(12, 1);
		n_map = $urandom_range(16, 1);
		for (int i = 0; i < n_measure; i++) begin
			px = pix_t'($urandom_range(hi_b, lo_b));
			send_request(OP_MEASURE, px, i == 0);
		end
		for (int i = 0; i < n_map; i++) begin
			if ($urandom_range(3) == 0)
				px = pix_t'($urandom_range(255));
			else
				px = pix_t'($urandom_range(hi_b, lo_b));
			send_request(OP_MAP, px, $urandom_range(15) == 0);
		end
	endtask

	// Stimulus and end of run.
	initial begin
		calm = 1'b0;
		requests_sent = 0;
		arst_n <= 1'b0;
		pix_in_bus.valid  <= 1'b0;
		pix_in_bus.opcode <= OP_MEASURE;
		pix_in_bus.pixel  <= '0;
		pix_in_bus.first  <= 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Map before any measure: extremes are both zero, pixels pass through.
		send_request(OP_MAP, 8'h00, 1'b0);
		send_request(OP_MAP, 8'hFF, 1'b0);
		// Measure with no first mark grows from the reset extremes.
		send_request(OP_MEASURE, 8'h80, 1'b0);
		send_request(OP_MEASURE, 8'h30, 1'b0);
		send_request(OP_MAP, 8'h40, 1'b0);
		// A first mark on a map request is ignored.
		send_request(OP_MAP, 8'h90, 1'b1);
		// Flat image: pixels pass through unchanged.
		send_request(OP_MEASURE, 8'h40, 1'b1);
		send_request(OP_MAP, 8'h40, 1'b0);
		send_request(OP_MAP, 8'h10, 1'b0);
		// Saturation below the minimum and above the maximum.
		send_request(OP_MEASURE, 8'hC0, 1'b0);
		send_request(OP_MEASURE, 8'h20, 1'b0);
		send_request(OP_MAP, 8'h10, 1'b0);
		send_request(OP_MAP, 8'h20, 1'b0);
		send_request(OP_MAP, 8'hC0, 1'b0);
		send_request(OP_MAP, 8'hF0, 1'b0);
		send_request(OP_MAP, 8'h21, 1'b0);
		send_request(OP_MAP, 8'hBF, 1'b0);
		// Full range, then a flat image at the top.
		send_request(OP_MEASURE, 8'h00, 1'b1);
		send_request(OP_MEASURE, 8'hFF, 1'b0);
		send_request(OP_MAP, 8'h7F, 1'b0);
		send_request(OP_MAP, 8'h01, 1'b0);
		send_request(OP_MAP, 8'hFE, 1'b0);
		send_request(OP_MEASURE, 8'hFF, 1'b1);
		send_request(OP_MAP, 8'hFF, 1'b0);
		send_request(OP_MAP, 8'h00, 1'b0);

		// Random images, with a little noise between them.
		while (requests_sent < 1900) begin
			calm = (requests_sent >= 700 && requests_sent < 1000);
			if ($urandom_range(99) < 85) begin
				send_image();
			end else begin
				repeat ($urandom_range(6, 1))
					send_request(logic'($urandom_range(1)), pix_t'($urandom_range(255)),
						logic'($urandom_range(1)));
			end
		end
		calm = 1'b0;

		// Drop valid at the edge of the last acceptance, then drain the block.
		pix_in_bus.valid <= 1'b0;
		while (board.owed_pixels.size() != 0)
			@(posedge clk);
		repeat (30) @(posedge clk);

		if (board.errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
